>>> rtl/fht_pkg.sv
package fht_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 24;
  localparam int ROT_W      = 24;
  localparam int TRANS_W    = 32;
  localparam int NUM_W      = 56;
  localparam int ROOT_W     = 32;

  localparam logic [1:0] ROLE_NASION    = 2'd0;
  localparam logic [1:0] ROLE_LEFT_EAR  = 2'd1;
  localparam logic [1:0] ROLE_RIGHT_EAR = 2'd2;
  localparam logic [1:0] ROLE_EXTRA     = 2'd3;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_op_t;

  typedef struct packed {
    logic               go;
    sd_op_t             op;
    logic [63:0]        rad;
    logic [NUM_W-1:0]   num;
    logic [ROOT_W-1:0]  den;
  } sd_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ROOT_W-1:0]  value;
  } sd_rsp_t;

  // round half away from zero after an arithmetic right shift
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    r   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

>>> rtl/fht_if.sv
interface fht_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  start_of_set;
  logic signed [fht_pkg::COORD_W-1:0]    point_x;
  logic signed [fht_pkg::COORD_W-1:0]    point_y;
  logic signed [fht_pkg::COORD_W-1:0]    point_z;

  modport source (output valid, start_of_set, point_x, point_y, point_z, input ready);
  modport sink   (input valid, start_of_set, point_x, point_y, point_z, output ready);
endinterface

interface fht_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fht_pkg::COORD_W-1:0]    head_x;
  logic signed [fht_pkg::COORD_W-1:0]    head_y;
  logic signed [fht_pkg::COORD_W-1:0]    head_z;
  logic [1:0]                            point_role;
  logic [fht_pkg::CNT_W-1:0]             extra_number;
  logic                                  frame_bad;
  logic                                  last_of_run;

  modport source (output valid, head_x, head_y, head_z, point_role, extra_number,
                  frame_bad, last_of_run, input ready);
  modport sink   (input valid, head_x, head_y, head_z, point_role, extra_number,
                  frame_bad, last_of_run, output ready);
endinterface

>>> rtl/fiducial_head_frame_transform_core.sv
// Head frame transform core.
// in_chan (valid/ready) takes one 3D point per transaction, Q3.20 metres.
// start_of_set marks the nasion; the next two points are the left and right
// ear. Fiducials give no result until the right ear arrives, then the frame
// is built and three results follow (nasion, left ear, right ear). Later
// points, up to MAX_POINTS per set, give one result each, rotated and
// translated into the head frame. out_chan (valid/ready) carries results;
// last_of_run marks the final one of an input transaction.
// Items are handled one at a time; in_chan.ready is high only when idle.
// An extra point takes 12 multiply/accumulate steps, each a multiply and an
// accumulate state, on the single shared 32x32 multiplier, plus a write-back
// per coordinate. The frame build is dominated by three normalizations, each
// a one-bit-per-cycle shift, a 32-step square root and three 24-step
// divisions in the shared root/divide unit; a zero vector skips the root and
// the divisions.
// A held result stays on out_chan while out_chan.ready is low, and the core
// waits. Reset clears the set, the frame and out_chan.valid.
module fiducial_head_frame_transform_core (
  input logic       clk,
  input logic       rst_n,
  fht_in_if.sink    in_chan,
  fht_out_if.source out_chan
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_ACC, ST_WB, ST_UMAX, ST_UNORM,
    ST_SQRT, ST_DGO, ST_DIV, ST_UDONE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    J_DW, J_ZX, J_SQ, J_TR, J_EM
  } job_t;

  state_t state_r;
  job_t   job_r;

  logic signed [23:0] fid_r [9];
  logic signed [23:0] pin_r [3];
  logic signed [25:0] o_r   [3];
  logic signed [26:0] d_r   [3];
  logic signed [24:0] w_r   [3];
  logic signed [55:0] v_r   [3];
  logic        [55:0] a_r   [3];
  logic signed [23:0] rx_r  [3];
  logic signed [23:0] ry_r  [3];
  logic signed [23:0] rz_r  [3];
  logic signed [31:0] tr_r  [3];
  logic signed [23:0] h_r   [3];

  logic [fht_pkg::CNT_W-1:0] cnt_r, xnum_r;
  logic        flag_r;
  logic [1:0]  fstep_r, ci_r, ti_r, role_r;
  logic signed [63:0] prod_r, acc_r;
  logic [fht_pkg::ROOT_W-1:0] m_r;
  logic        out_valid_r;
  fht_pkg::sd_req_t req_r;
  fht_pkg::sd_rsp_t rsp;

  logic signed [31:0] opa, opb;
  logic        neg;
  logic [1:0]  last_t;
  logic [1:0]  i1, i2, ta, tb;
  logic [3:0]  fidx;
  logic [55:0] mx01, mx;
  logic signed [25:0] o_c [3];
  logic signed [26:0] d_c [3];
  logic signed [24:0] w_c [3];
  logic signed [63:0] acc_nxt;
  logic signed [63:0] tr_rnd;
  logic [fht_pkg::ROOT_W-1:0] q;
  logic signed [23:0] qs;
  logic [fht_pkg::CNT_W-1:0] xn;

  fht_sqdiv u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_c[i] = 26'(fid_r[3 + i]) + 26'(fid_r[6 + i]);
      d_c[i] = (27'(fid_r[i]) <<< 1) - 27'(o_c[i]);
      w_c[i] = 25'(fid_r[3 + i]) - 25'(fid_r[6 + i]);
    end
  end

  always_comb begin
    case (ci_r)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    ta   = ti_r[0] ? i2 : i1;
    tb   = ti_r[0] ? i1 : i2;
    fidx = 4'(role_r) * 4'd3 + 4'(ti_r);
    opa  = '0;
    opb  = '0;
    neg  = 1'b0;
    last_t = 2'd2;
    case (job_r)
      J_DW: begin
        opa = 32'(d_r[ta]);
        opb = 32'(w_r[tb]);
        neg = ti_r[0];
        last_t = 2'd1;
      end
      J_ZX: begin
        opa = 32'(rz_r[ta]);
        opb = 32'(rx_r[tb]);
        neg = ti_r[0];
        last_t = 2'd1;
      end
      J_SQ: begin
        opa = signed'(a_r[ti_r][31:0]);
        opb = signed'(a_r[ti_r][31:0]);
      end
      J_TR: begin
        opb = 32'(o_r[ti_r]);
        case (ci_r)
          2'd0:    opa = 32'(rx_r[ti_r]);
          2'd1:    opa = 32'(ry_r[ti_r]);
          default: opa = 32'(rz_r[ti_r]);
        endcase
      end
      J_EM: begin
        last_t = 2'd3;
        if (ti_r == 2'd3) begin
          opa = tr_r[ci_r];
          opb = 32'sd1 <<< 22;
        end else begin
          case (ci_r)
            2'd0:    opa = 32'(rx_r[ti_r]);
            2'd1:    opa = 32'(ry_r[ti_r]);
            default: opa = 32'(rz_r[ti_r]);
          endcase
          if (role_r == fht_pkg::ROLE_EXTRA) begin
            opb = 32'(pin_r[ti_r]);
          end else begin
            opb = 32'(fid_r[fidx]);
          end
        end
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    mx01    = (a_r[0] > a_r[1]) ? a_r[0] : a_r[1];
    mx      = (mx01 > a_r[2]) ? mx01 : a_r[2];
    acc_nxt = neg ? (acc_r - prod_r) : (acc_r + prod_r);
    tr_rnd  = fht_pkg::round_shift(acc_r, 23);
    q       = rsp.value;
    qs      = v_r[ci_r][55] ? -signed'(q[23:0]) : signed'(q[23:0]);
    xn      = cnt_r - fht_pkg::CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= J_EM;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      req_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        rx_r[i] <= '0;
        ry_r[i] <= '0;
        rz_r[i] <= '0;
        tr_r[i] <= '0;
      end
    end else begin
      req_r.go <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            if (in_chan.start_of_set) begin
              fid_r[0] <= in_chan.point_x;
              fid_r[1] <= in_chan.point_y;
              fid_r[2] <= in_chan.point_z;
              cnt_r    <= fht_pkg::CNT_W'(1);
            end else if (cnt_r == fht_pkg::CNT_W'(0)) begin
              cnt_r <= cnt_r;
            end else if (cnt_r == fht_pkg::CNT_W'(1)) begin
              fid_r[3] <= in_chan.point_x;
              fid_r[4] <= in_chan.point_y;
              fid_r[5] <= in_chan.point_z;
              cnt_r    <= fht_pkg::CNT_W'(2);
            end else if (cnt_r == fht_pkg::CNT_W'(2)) begin
              fid_r[6] <= in_chan.point_x;
              fid_r[7] <= in_chan.point_y;
              fid_r[8] <= in_chan.point_z;
              cnt_r    <= fht_pkg::CNT_W'(3);
              state_r  <= ST_PREP;
            end else if (xn <= fht_pkg::CNT_W'(fht_pkg::MAX_POINTS)) begin
              pin_r[0] <= in_chan.point_x;
              pin_r[1] <= in_chan.point_y;
              pin_r[2] <= in_chan.point_z;
              xnum_r   <= xn;
              cnt_r    <= cnt_r + fht_pkg::CNT_W'(1);
              role_r   <= fht_pkg::ROLE_EXTRA;
              job_r    <= J_EM;
              ci_r     <= '0;
              ti_r     <= '0;
              acc_r    <= '0;
              state_r  <= ST_MUL;
            end
          end
        end
        ST_PREP: begin
          for (int i = 0; i < 3; i++) begin
            o_r[i] <= o_c[i];
            d_r[i] <= d_c[i];
            w_r[i] <= w_c[i];
            v_r[i] <= 56'(d_c[i]);
          end
          flag_r  <= 1'b0;
          fstep_r <= 2'd0;
          state_r <= ST_UMAX;
        end
        ST_UMAX: begin
          for (int i = 0; i < 3; i++) begin
            a_r[i] <= v_r[i][55] ? 56'(-v_r[i]) : 56'(v_r[i]);
          end
          state_r <= ST_UNORM;
        end
        ST_UNORM: begin
          if (mx == '0) begin
            flag_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              case (fstep_r)
                2'd0:    rx_r[i] <= '0;
                2'd1:    rz_r[i] <= '0;
                default: ry_r[i] <= '0;
              endcase
            end
            state_r <= ST_UDONE;
          end else if (|mx[55:30]) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
          end else if (mx[55:29] == '0) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
          end else begin
            job_r   <= J_SQ;
            ci_r    <= '0;
            ti_r    <= '0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= opa * opb;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_nxt;
          if (ti_r == last_t) begin
            state_r <= ST_WB;
          end else begin
            ti_r    <= ti_r + 2'd1;
            state_r <= ST_MUL;
          end
        end
        ST_WB: begin
          ti_r  <= '0;
          acc_r <= '0;
          case (job_r)
            J_DW, J_ZX: begin
              v_r[ci_r] <= acc_r[55:0];
              if (ci_r == 2'd2) begin
                state_r <= ST_UMAX;
              end else begin
                ci_r    <= ci_r + 2'd1;
                state_r <= ST_MUL;
              end
            end
            J_SQ: begin
              req_r.go  <= 1'b1;
              req_r.op  <= fht_pkg::SD_SQRT;
              req_r.rad <= acc_r;
              state_r   <= ST_SQRT;
            end
            J_TR: begin
              tr_r[ci_r] <= -signed'(tr_rnd[31:0]);
              if (ci_r == 2'd2) begin
                role_r  <= fht_pkg::ROLE_NASION;
                xnum_r  <= '0;
                job_r   <= J_EM;
                ci_r    <= '0;
              end else begin
                ci_r <= ci_r + 2'd1;
              end
              state_r <= ST_MUL;
            end
            default: begin
              h_r[ci_r] <= fht_pkg::sat24(fht_pkg::round_shift(acc_r, 22));
              if (ci_r == 2'd2) begin
                out_valid_r <= 1'b1;
                state_r     <= ST_OUT;
              end else begin
                ci_r    <= ci_r + 2'd1;
                state_r <= ST_MUL;
              end
            end
          endcase
        end
        ST_SQRT: begin
          if (rsp.done) begin
            m_r     <= rsp.value;
            ci_r    <= '0;
            state_r <= ST_DGO;
          end
        end
        ST_DGO: begin
          req_r.go  <= 1'b1;
          req_r.op  <= fht_pkg::SD_DIV;
          req_r.num <= (a_r[ci_r] << 22) + 56'(m_r >> 1);
          req_r.den <= m_r;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          if (rsp.done) begin
            case (fstep_r)
              2'd0:    rx_r[ci_r] <= qs;
              2'd1:    rz_r[ci_r] <= qs;
              default: ry_r[ci_r] <= qs;
            endcase
            if (ci_r == 2'd2) begin
              state_r <= ST_UDONE;
            end else begin
              ci_r    <= ci_r + 2'd1;
              state_r <= ST_DGO;
            end
          end
        end
        ST_UDONE: begin
          ci_r    <= '0;
          ti_r    <= '0;
          acc_r   <= '0;
          state_r <= ST_MUL;
          fstep_r <= fstep_r + 2'd1;
          case (fstep_r)
            2'd0:    job_r <= J_DW;
            2'd1:    job_r <= J_ZX;
            default: job_r <= J_TR;
          endcase
        end
        ST_OUT: begin
          if (out_chan.ready) begin
            out_valid_r <= 1'b0;
            if (role_r == fht_pkg::ROLE_NASION || role_r == fht_pkg::ROLE_LEFT_EAR) begin
              role_r  <= role_r + 2'd1;
              job_r   <= J_EM;
              ci_r    <= '0;
              ti_r    <= '0;
              acc_r   <= '0;
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.head_x       = h_r[0];
  assign out_chan.head_y       = h_r[1];
  assign out_chan.head_z       = h_r[2];
  assign out_chan.point_role   = role_r;
  assign out_chan.extra_number = xnum_r;
  assign out_chan.frame_bad    = flag_r;
  assign out_chan.last_of_run  = (role_r == fht_pkg::ROLE_RIGHT_EAR) ||
                                 (role_r == fht_pkg::ROLE_EXTRA);

endmodule

>>> rtl/fht_sqdiv.sv
// Shared square root / divider, one result bit per cycle.
module fht_sqdiv (
  input  logic             clk,
  input  logic             rst_n,
  input  fht_pkg::sd_req_t req,
  output fht_pkg::sd_rsp_t rsp
);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 24;

  fht_pkg::sd_op_t op_r;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] z_r, z_nxt;
  logic [5:0]  cnt_r;
  logic [fht_pkg::ROOT_W-1:0] den_r;
  logic        busy_r, done_r;
  logic [fht_pkg::ROOT_W-1:0] value_r;
  logic [63:0] trial;
  logic [32:0] r2;

  always_comb begin
    trial = y_r + z_r;
    r2    = {x_r[31:0], z_r[DIV_STEPS-1]};
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    case (op_r)
      fht_pkg::SD_SQRT: begin
        if (x_r >= trial) begin
          x_nxt = x_r - trial;
          y_nxt = (y_r >> 1) + z_r;
        end else begin
          y_nxt = y_r >> 1;
        end
        z_nxt = z_r >> 2;
      end
      fht_pkg::SD_DIV: begin
        if (r2 >= {1'b0, den_r}) begin
          x_nxt = 64'(r2 - {1'b0, den_r});
          y_nxt = {y_r[62:0], 1'b1};
        end else begin
          x_nxt = 64'(r2);
          y_nxt = {y_r[62:0], 1'b0};
        end
        z_nxt = z_r << 1;
      end
      default: begin
        x_nxt = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        op_r   <= req.op;
        busy_r <= 1'b1;
        den_r  <= req.den;
        y_r    <= '0;
        if (req.op == fht_pkg::SD_SQRT) begin
          x_r   <= req.rad;
          z_r   <= 64'd1 << 62;
          cnt_r <= 6'(SQRT_STEPS);
        end else begin
          x_r   <= 64'(req.num[fht_pkg::NUM_W-1:DIV_STEPS]);
          z_r   <= 64'(req.num[DIV_STEPS-1:0]);
          cnt_r <= 6'(DIV_STEPS);
        end
      end else if (busy_r) begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        z_r   <= z_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          value_r <= y_nxt[fht_pkg::ROOT_W-1:0];
        end
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

>>> rtl/fht_checker.sv
module fht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  point_role,
  input logic [10:0] extra_number,
  input logic        last_of_run
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(point_role))
    else $error("stalled result dropped");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_extra_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && point_role == fht_pkg::ROLE_EXTRA |-> last_of_run && extra_number != '0)
    else $error("bad extra point fields");

  a_fid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && point_role != fht_pkg::ROLE_EXTRA |->
      extra_number == '0 && last_of_run == (point_role == fht_pkg::ROLE_RIGHT_EAR))
    else $error("bad fiducial fields");

endmodule

bind fiducial_head_frame_transform_core fht_checker u_fht_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .point_role   (out_chan.point_role),
  .extra_number (out_chan.extra_number),
  .last_of_run  (out_chan.last_of_run)
);

>>> tb/tb_fiducial_head_frame_transform_core.sv
`timescale 1ns / 1ps

module tb_fiducial_head_frame_transform_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fht_in_if  in_chan ();
  fht_out_if out_chan ();

  fiducial_head_frame_transform_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  typedef struct packed {
    logic signed [23:0] hx;
    logic signed [23:0] hy;
    logic signed [23:0] hz;
    logic [1:0]         role;
    logic [10:0]        num;
    logic               bad;
    logic               last;
  } head_pt_t;

  typedef struct {
    logic               sos;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               has_exp;
    head_pt_t           exp0;
  } row_t;

  // frame tracker state
  longint fid [9];
  longint rot [9];
  longint trn [3];
  int     set_cnt;
  bit     degen;

  head_pt_t pending_pts[$];
  row_t     dir_rows[$];
  int       errors = 0;
  int       n_in = 0;
  int       n_out = 0;
  int       n_sets = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       quiet = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint a;
    a = (mag(v) + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -a : a;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic normalize(input longint v[3], output longint u[3]);
    longint unsigned a[3], mx, s, m, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = mag(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      degen = 1;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) a[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) a[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += a[i] * a[i];
    m = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 22) + (m >> 1)) / m;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  task automatic build_head_frame();
    longint o[3], d[3], w[3], zt[3], ex[3], ey[3], ez[3], yt[3], dot;
    degen = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = fid[3+i] + fid[6+i];
      d[i] = 2 * fid[i] - o[i];
      w[i] = fid[3+i] - fid[6+i];
    end
    normalize(d, ex);
    cross3(d, w, zt);
    normalize(zt, ez);
    cross3(ez, ex, yt);
    normalize(yt, ey);
    for (int i = 0; i < 3; i++) begin
      rot[i] = ex[i];
      rot[3+i] = ey[i];
      rot[6+i] = ez[i];
    end
    for (int i = 0; i < 3; i++) begin
      dot = rot[3*i] * o[0] + rot[3*i+1] * o[1] + rot[3*i+2] * o[2];
      trn[i] = -rnd_shift(dot, 23);
    end
  endtask

  function automatic head_pt_t to_head(longint p0, longint p1, longint p2,
                                       logic [1:0] role, int num, bit last);
    head_pt_t r;
    longint acc[3];
    for (int i = 0; i < 3; i++)
      acc[i] = clip24(rnd_shift(rot[3*i] * p0 + rot[3*i+1] * p1 + rot[3*i+2] * p2
                                + trn[i] * (64'sd1 <<< 22), 22));
    r.hx = acc[0][23:0];
    r.hy = acc[1][23:0];
    r.hz = acc[2][23:0];
    r.role = role;
    r.num = num[10:0];
    r.bad = degen;
    r.last = last;
    return r;
  endfunction

  task automatic track_point(input logic sos, input logic signed [23:0] x,
                             input logic signed [23:0] y, input logic signed [23:0] z);
    longint p[3];
    p = '{longint'(x), longint'(y), longint'(z)};
    if (sos) begin
      for (int i = 0; i < 3; i++) fid[i] = p[i];
      set_cnt = 1;
    end else if (set_cnt == 1) begin
      for (int i = 0; i < 3; i++) fid[3+i] = p[i];
      set_cnt = 2;
    end else if (set_cnt == 2) begin
      for (int i = 0; i < 3; i++) fid[6+i] = p[i];
      set_cnt = 3;
      n_sets++;
      build_head_frame();
      pending_pts.push_back(to_head(fid[0], fid[1], fid[2], fht_pkg::ROLE_NASION,
                                    0, 1'b0));
      pending_pts.push_back(to_head(fid[3], fid[4], fid[5], fht_pkg::ROLE_LEFT_EAR,
                                    0, 1'b0));
      pending_pts.push_back(to_head(fid[6], fid[7], fid[8], fht_pkg::ROLE_RIGHT_EAR,
                                    0, 1'b1));
    end else if (set_cnt >= 3 && set_cnt - 2 <= fht_pkg::MAX_POINTS) begin
      pending_pts.push_back(to_head(p[0], p[1], p[2], fht_pkg::ROLE_EXTRA,
                                    set_cnt - 2, 1'b1));
      set_cnt++;
    end
  endtask

  task automatic send_point(input logic sos, input logic signed [23:0] x,
                            input logic signed [23:0] y, input logic signed [23:0] z);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.start_of_set <= sos;
    in_chan.point_x <= x;
    in_chan.point_y <= y;
    in_chan.point_z <= z;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    track_point(sos, x, y, z);
    n_in++;
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rnd_coord(int k);
    case (k)
      0: return 24'(signed'($urandom_range(400000, 0)) - 200000);
      1: return 24'($urandom);
      default: return 24'(signed'($urandom_range(2000, 0)) - 1000);
    endcase
  endfunction

  task automatic random_set(int extras, int k);
    send_point(1'b1, rnd_coord(k), rnd_coord(k), rnd_coord(k));
    send_point(1'b0, rnd_coord(k), rnd_coord(k), rnd_coord(k));
    send_point(1'b0, rnd_coord(k), rnd_coord(k), rnd_coord(k));
    for (int i = 0; i < extras; i++)
      send_point(1'b0, rnd_coord(k), rnd_coord(k), rnd_coord(k));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      head_pt_t got, want;
      got = '{out_chan.head_x, out_chan.head_y, out_chan.head_z, out_chan.point_role,
              out_chan.extra_number, out_chan.frame_bad, out_chan.last_of_run};
      n_out++;
      if (pending_pts.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: got %p", $time, got);
      end else begin
        want = pending_pts.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= !(recv_idle > 0 && $urandom_range(99, 0) < recv_idle);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t r;
    head_pt_t got;
    in_chan.valid = 1'b0;
    in_chan.start_of_set = 1'b0;
    in_chan.point_x = '0;
    in_chan.point_y = '0;
    in_chan.point_z = '0;
    out_chan.ready = 1'b1;
    set_cnt = 0;
    degen = 0;
    foreach (fid[i]) fid[i] = 0;
    foreach (rot[i]) rot[i] = 0;
    trn = '{0, 0, 0};

    // directed rows; typed expectation is checked against the tracker too
    dir_rows = '{
      '{0, 24'sd100, 24'sd200, 24'sd300, 0, '0},           // no open set
      '{1, 24'sd1048576, 24'sd0, 24'sd0, 0, '0},
      '{0, 24'sd0, 24'sd1048576, 24'sd0, 0, '0},
      '{0, 24'sd0, -24'sd1048576, 24'sd0, 0, '0},
      '{0, 24'sd0, 24'sd0, 24'sd0, 1, '{24'sd0, 24'sd0, 24'sd0, fht_pkg::ROLE_EXTRA,
                                        11'd1, 1'b0, 1'b1}},
      '{0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, '0},
      '{0, 24'sh800000, 24'sh800000, 24'sh800000, 0, '0},
      '{1, 24'sd5, 24'sd5, 24'sd5, 0, '0},                  // new set early
      '{0, 24'sd7, 24'sd7, 24'sd7, 0, '0},
      '{1, 24'sd9, 24'sd9, 24'sd9, 0, '0},                  // all coincident: degenerate
      '{0, 24'sd9, 24'sd9, 24'sd9, 0, '0},
      '{0, 24'sd9, 24'sd9, 24'sd9, 0, '0},
      '{0, 24'sd1, 24'sd2, 24'sd3, 0, '0},
      '{1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 0, '0},   // extreme fiducials
      '{0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 0, '0},
      '{0, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 0, '0},
      '{0, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 0, '0},
      '{1, 24'sd0, 24'sd0, 24'sd0, 0, '0},                  // collinear ears
      '{0, 24'sd1000, 24'sd0, 24'sd0, 0, '0},
      '{0, -24'sd1000, 24'sd0, 24'sd0, 0, '0},
      '{0, 24'sd3, 24'sd4, 24'sd5, 0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_point(r.sos, r.x, r.y, r.z);
      if (r.has_exp) begin
        if (pending_pts.size() == 0) begin
          errors++;
          $display("%0t table mismatch row %0d: expected %p actual none",
                   $time, i, r.exp0);
        end else begin
          got = pending_pts[$];
          if (got !== r.exp0) begin
            errors++;
            $display("%0t table mismatch row %0d: expected %p actual %p",
                     $time, i, r.exp0, got);
          end
        end
      end
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < 9; s++) begin
        if ($urandom_range(5, 0) == 0)
          send_point(1'($urandom_range(1, 0)), rnd_coord(1), rnd_coord(1), rnd_coord(1));
        else if ($urandom_range(7, 0) == 0) begin
          send_point(1'b1, rnd_coord(0), rnd_coord(0), rnd_coord(0));
          send_point(1'b0, rnd_coord(0), rnd_coord(0), rnd_coord(0));
        end else
          random_set($urandom_range(4, 0), $urandom_range(2, 0));
      end
      send_idle = 0;
      drain();
    end

    drain();
    repeat (600) @(posedge clk);
    $display("Ran %0d input transactions over %0d frames, %0d results checked.",
             n_in, n_sets, n_out);
    $display("Covered degenerate, early restart, saturation and all idle mixes.");
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fht_pkg.sv
rtl/fht_if.sv
rtl/fht_sqdiv.sv
rtl/fiducial_head_frame_transform_core.sv
rtl/fht_checker.sv
tb/tb_fiducial_head_frame_transform_core.sv
